// ----- hdl/cfc_pkg.sv -----
// shared types, constants and the crc-16/modbus byte update for the wheel-count deframer
// no dependencies
package cfc_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int CRC_W       = 16;
    localparam int NUM_WHEELS  = 4;
    localparam int BODY_LEN    = 18;
    localparam int PAYLOAD_LEN = 16;
    localparam int IDX_W       = $clog2(BODY_LEN);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'h88;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'hAA;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_SYNC  = 1'b0,
        CFG_SECOND_SYNC = 1'b1
    } cfg_index_t;

    // one finished frame as handed to the output stage
    typedef struct packed {
        logic                               good;
        logic [NUM_WHEELS-1:0][WORD_W-1:0]  delta;
        logic [NUM_WHEELS-1:0][WORD_W-1:0]  count;
    } cfc_result_t;

    // reflected crc-16 update over one byte, lsb first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/cfc_deframer.sv -----
// sync hunt, body capture, running crc and stored wheel counts
// depends on cfc_pkg
module cfc_deframer import cfc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [BYTE_W-1:0]      cfg_wdata,
    input  logic                   byte_valid,
    input  logic [BYTE_W-1:0]      byte_data,
    output logic                   frame_ending,
    output cfc_result_t            result
);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_SYNC2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(BODY_LEN - 1);
    localparam logic [IDX_W-1:0] PAYLOAD_END = IDX_W'(PAYLOAD_LEN);

    phase_t                            phase_reg, phase_next;
    logic [IDX_W-1:0]                  index_reg, index_next;
    logic [CRC_W-1:0]                  crc_reg, crc_next;
    logic [BYTE_W-1:0]                 first_sync_reg, second_sync_reg;
    logic [NUM_WHEELS-1:0][WORD_W-1:0] counts_reg, counts_next;
    // last body byte is taken straight from the input, so only 17 are kept
    logic [BYTE_W-1:0]                 body_mem [BODY_LEN-1];
    logic                              body_we;
    logic                              good;
    logic [NUM_WHEELS-1:0][WORD_W-1:0] new_word;

    assign frame_ending = (phase_reg == PH_BODY) && (index_reg == LAST_IDX);

    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            new_word[i] = {body_mem[4*i], body_mem[4*i+1], body_mem[4*i+2], body_mem[4*i+3]};
        end
        good = ({body_mem[PAYLOAD_LEN], byte_data} == crc_reg);
    end

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        crc_next    = crc_reg;
        counts_next = counts_reg;
        body_we     = 1'b0;
        result.good = good;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            result.count[i] = good ? new_word[i] : counts_reg[i];
            result.delta[i] = good ? (new_word[i] - counts_reg[i]) : '0;
        end
        if (byte_valid) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (byte_data == first_sync_reg) begin
                        phase_next = PH_SYNC2;
                        index_next = '0;
                    end
                end
                PH_SYNC2: begin
                    phase_next = (byte_data == second_sync_reg) ? PH_BODY : PH_HUNT;
                    index_next = '0;
                    crc_next   = CRC_INIT;
                end
                PH_BODY: begin
                    if (index_reg > LAST_IDX) begin
                        phase_next = PH_HUNT;
                        index_next = '0;
                    end else if (index_reg == LAST_IDX) begin
                        phase_next = PH_HUNT;
                        index_next = '0;
                        if (good) begin
                            counts_next = new_word;
                        end
                    end else begin
                        body_we    = 1'b1;
                        index_next = index_reg + 1'b1;
                        if (index_reg < PAYLOAD_END) begin
                            crc_next = crc16_byte(crc_reg, byte_data);
                        end
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                    index_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            index_reg       <= '0;
            crc_reg         <= CRC_INIT;
            counts_reg      <= '0;
            first_sync_reg  <= FIRST_SYNC_RESET;
            second_sync_reg <= SECOND_SYNC_RESET;
        end else begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            crc_reg    <= crc_next;
            counts_reg <= counts_next;
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_FIRST_SYNC:  first_sync_reg  <= cfg_wdata;
                    CFG_SECOND_SYNC: second_sync_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (body_we) begin
            body_mem[index_reg] <= byte_data;
        end
    end

endmodule

// ----- hdl/crc16_framed_counter_receiver.sv -----
// top level of the wheel-count frame receiver: input register, deframer, result register
// depends on cfc_pkg and cfc_deframer
//
// usage
//   s_ channel carries one received serial byte per request. the block hunts for
//   the first sync byte, requires the second sync byte right after it, then
//   collects 18 body bytes: four big-endian 32-bit wheel counts and a
//   crc-16/modbus of those 16 bytes, crc high byte first
//   m_ channel carries one request per completed frame: crc status in tuser,
//   the stored counts and their wrapping differences in tdata. a bad crc gives
//   the unchanged counts and zero differences
//   sync byte values are set through the cfg_ write port (index 0 first, 1 second)
//   while the block is idle
// timing
//   one byte per cycle sustained unless a waiting result stalls the input: each byte is
//   held in the input register, crc update and frame checks run in one pass into the
//   result register, which is loaded when the deframer takes the last body byte
// reset and stall
//   reset empties both registers, returns to hunting, clears the stored counts
//   and restores the default sync bytes. while a result waits on m_tready the
//   block keeps taking bytes until the next frame end would need the result
//   register; then the input register holds and s_tready drops
module crc16_framed_counter_receiver import cfc_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]            cfg_addr,
    input  logic [BYTE_W-1:0]               cfg_wdata,
    // byte input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [BYTE_W-1:0]               s_tdata,   // [7:0] rx_byte
    // frame result
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] left_front_count, [63:32] right_front_count, [95:64] left_back_count,
    // [127:96] right_back_count, [159:128] left_front_delta, [191:160] right_front_delta,
    // [223:192] left_back_delta, [255:224] right_back_delta
    output logic [2*NUM_WHEELS*WORD_W-1:0]  m_tdata,
    output logic [0:0]                      m_tuser    // [0] frame_good
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              m_valid_reg;
    cfc_result_t       res_reg;

    logic              frame_ending;
    cfc_result_t       result;
    logic              advance;
    logic              load;

    // a byte moves on unless it ends a frame and the result register is still full
    assign advance  = in_valid_reg && (!frame_ending || !m_valid_reg || m_tready);
    assign load     = advance && frame_ending;
    assign s_tready = !in_valid_reg || advance;

    cfc_deframer u_deframer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .byte_valid   (advance),
        .byte_data    (in_byte_reg),
        .frame_ending (frame_ending),
        .result       (result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {res_reg.delta, res_reg.count};
    assign m_tuser[0] = res_reg.good;

    // a new frame result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_tready))
        else $error("frame result overwritten while stalled");

    // a held byte stays put until the deframer takes it
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte lost or changed");

    // a failed frame carries zero differences
    a_bad_zero_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.good) |-> (res_reg.delta == '0))
        else $error("bad frame with nonzero delta");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !in_valid_reg))
        else $error("registers not empty after reset");

endmodule

// ----- tb/wheel_frame_check_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard for the wheel-count frame receiver: byte-level deframer prediction and result compare
// depends on cfc_pkg for widths, sync reset values and register indexes
package wheel_frame_check_pkg;

    import cfc_pkg::*;

    typedef enum logic [1:0] {
        SEEK_FIRST  = 2'd0,
        SEEK_SECOND = 2'd1,
        IN_BODY     = 2'd2
    } parse_state_t;

    typedef struct packed {
        logic                               good;
        logic [NUM_WHEELS-1:0][WORD_W-1:0]  count;
        logic [NUM_WHEELS-1:0][WORD_W-1:0]  delta;
    } frame_report_t;

    class frame_scoreboard;
        logic [BYTE_W-1:0]  first_sync;
        logic [BYTE_W-1:0]  second_sync;
        parse_state_t       state;
        int unsigned        body_pos;
        logic [CRC_W-1:0]   crc_acc;
        logic [BYTE_W-1:0]  body [BODY_LEN];
        logic [WORD_W-1:0]  stored [NUM_WHEELS];
        frame_report_t      awaited [$];
        int unsigned        errors;
        int unsigned        frames_seen;

        function new();
            first_sync  = FIRST_SYNC_RESET;
            second_sync = SECOND_SYNC_RESET;
            state       = SEEK_FIRST;
            body_pos    = 0;
            crc_acc     = CRC_INIT;
            errors      = 0;
            frames_seen = 0;
            foreach (stored[w]) stored[w] = '0;
        endfunction

        // bit-serial crc-16/modbus, data lsb first
        static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] acc, logic [BYTE_W-1:0] d);
            logic fb;
            for (int j = 0; j < BYTE_W; j++) begin
                fb  = acc[0] ^ d[j];
                acc = acc >> 1;
                if (fb) acc = acc ^ CRC_POLY;
            end
            return acc;
        endfunction

        function void set_sync(cfg_index_t idx, logic [BYTE_W-1:0] v);
            if (idx == CFG_FIRST_SYNC) first_sync = v;
            else second_sync = v;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // one accepted byte request; queues the frame result it completes, if any
        function void note_byte(logic [BYTE_W-1:0] b);
            frame_report_t      r;
            logic [CRC_W-1:0]   rx_crc;
            logic [WORD_W-1:0]  fresh;
            case (state)
                SEEK_FIRST: begin
                    if (b == first_sync) begin
                        state    = SEEK_SECOND;
                        body_pos = 0;
                    end
                end
                SEEK_SECOND: begin
                    state    = (b == second_sync) ? IN_BODY : SEEK_FIRST;
                    body_pos = 0;
                    crc_acc  = CRC_INIT;
                end
                IN_BODY: begin
                    body[body_pos] = b;
                    if (body_pos < PAYLOAD_LEN) crc_acc = crc_step(crc_acc, b);
                    body_pos++;
                    if (body_pos == BODY_LEN) begin
                        state    = SEEK_FIRST;
                        body_pos = 0;
                        rx_crc   = {body[PAYLOAD_LEN], body[PAYLOAD_LEN+1]};
                        r.good   = (rx_crc == crc_acc);
                        for (int w = 0; w < NUM_WHEELS; w++) begin
                            if (r.good) begin
                                fresh = {body[4*w], body[4*w+1], body[4*w+2], body[4*w+3]};
                                r.delta[w] = fresh - stored[w];
                                stored[w]  = fresh;
                            end else begin
                                r.delta[w] = '0;
                            end
                            r.count[w] = stored[w];
                        end
                        awaited.push_back(r);
                    end
                end
                default: begin
                    state    = SEEK_FIRST;
                    body_pos = 0;
                end
            endcase
        endfunction

        function void flag(string what, logic [WORD_W-1:0] want_v, logic [WORD_W-1:0] got_v);
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %h, got %h", frames_seen, what, want_v, got_v);
        endfunction

        // one accepted result request, compared with the oldest queued frame
        function void check_frame(logic good, logic [2*NUM_WHEELS*WORD_W-1:0] data);
            frame_report_t want;
            frames_seen++;
            if (awaited.size() == 0) begin
                flag("unexpected result, frame_good", 'x, WORD_W'(good));
                return;
            end
            want = awaited.pop_front();
            if (good !== want.good) flag("frame_good", WORD_W'(want.good), WORD_W'(good));
            for (int w = 0; w < NUM_WHEELS; w++) begin
                if (data[WORD_W*w +: WORD_W] !== want.count[w])
                    flag($sformatf("wheel %0d count", w), want.count[w], data[WORD_W*w +: WORD_W]);
                if (data[NUM_WHEELS*WORD_W + WORD_W*w +: WORD_W] !== want.delta[w])
                    flag($sformatf("wheel %0d delta", w), want.delta[w],
                         data[NUM_WHEELS*WORD_W + WORD_W*w +: WORD_W]);
            end
        endfunction
    endclass

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// top of the wheel-count frame receiver test: directed frames, then random frame streams
// depends on cfc_pkg, wheel_frame_check_pkg and the crc16_framed_counter_receiver rtl
module testbench;

    import cfc_pkg::*;
    import wheel_frame_check_pkg::*;

    // no request in either direction for this long means the block is stuck;
    // random gaps and stalls are geometric, so runs of this length do not happen
    localparam int STALL_LIMIT   = 2000;
    // bytes of random stimulus per phase, eight phases in all
    localparam int PHASE_BYTES   = 175;
    localparam int NUM_PHASES    = 8;
    // input register plus result register, with margin
    localparam int SETTLE_CYCLES = 8;
    localparam int FRAME_LEN     = BODY_LEN + 2;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_addr  = '0;
    logic [BYTE_W-1:0]              cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [BYTE_W-1:0]              s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [2*NUM_WHEELS*WORD_W-1:0] m_tdata;
    logic [0:0]                     m_tuser;

    frame_scoreboard                    sb;
    int unsigned                        send_idle_pct  = 0;
    int unsigned                        recv_stall_pct = 0;
    int unsigned                        phase_bytes;
    logic [NUM_WHEELS-1:0][WORD_W-1:0]  last_counts = '0;

    crc16_framed_counter_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: check each result request, then pick ready for the next cycle.
    // values read right at the edge are the ones the block saw, since every
    // change at an edge lands in the nonblocking region
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_frame(m_tuser[0], m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no request accepted on either side
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("crc16_framed_counter_receiver verification failed");
        $finish;
    end

    // one byte request; random idle cycles go in front of it. tvalid stays high
    // after acceptance so back-to-back bytes never lower and raise it in one step
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
        phase_bytes++;
    endtask

    // header, big-endian counts and crc high byte first; optionally one bit
    // flipped after the crc is formed, optionally cut short after keep bytes
    task automatic send_frame(input logic [NUM_WHEELS-1:0][WORD_W-1:0] cnt,
                              input bit corrupt, input int unsigned keep);
        logic [BYTE_W-1:0]  frame [FRAME_LEN];
        logic [CRC_W-1:0]   crc;
        int unsigned        pos;
        frame[0] = sb.first_sync;
        frame[1] = sb.second_sync;
        crc = CRC_INIT;
        for (int w = 0; w < NUM_WHEELS; w++) begin
            for (int k = 0; k < 4; k++) begin
                frame[2 + 4*w + k] = cnt[w][8*(3-k) +: 8];
                crc = frame_scoreboard::crc_step(crc, frame[2 + 4*w + k]);
            end
        end
        frame[FRAME_LEN-2] = crc[15:8];
        frame[FRAME_LEN-1] = crc[7:0];
        if (corrupt) begin
            pos = $urandom_range(FRAME_LEN - 1, 2);
            frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(7));
        end
        for (int i = 0; i < keep; i++) send_byte(frame[i]);
    endtask

    // sender pause until every expected result is out, then let the pipe empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [BYTE_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_sync(idx, v);
        @(posedge aclk);
    endtask

    // counts: fully random, small steps around the last one (wraps at the
    // signed edges), the extremes, or the last one unchanged
    function automatic logic [WORD_W-1:0] pick_count(input logic [WORD_W-1:0] prev);
        case ($urandom_range(3))
            0: return $urandom;
            1: return prev + WORD_W'($urandom_range(200)) - 32'd100;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return prev;
        endcase
    endfunction

    initial begin
        logic [NUM_WHEELS-1:0][WORD_W-1:0]  cnt;
        logic [BYTE_W-1:0]                  sync_a [NUM_PHASES];
        logic [BYTE_W-1:0]                  sync_b [NUM_PHASES];
        logic [BYTE_W-1:0]                  bad_second;
        int unsigned                        pick;

        // phase 0 runs on the reset sync values; the rest cover the extremes,
        // equal sync bytes, a return to the defaults and random pairs
        sync_a = '{8'h88, 8'h00, 8'hFF, 8'h55, 8'h88, 8'h00, 8'hA5, 8'h00};
        sync_b = '{8'hAA, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h00, 8'h5A, 8'h00};
        sync_a[5] = BYTE_W'($urandom_range(255));
        sync_b[5] = BYTE_W'($urandom_range(255));
        sync_a[7] = BYTE_W'($urandom_range(255));
        sync_b[7] = BYTE_W'($urandom_range(255));

        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // first sync then first sync again: the second one is a wrong header
        // byte and must not restart the header, so the following second sync
        // byte is ignored while hunting
        send_byte(sb.first_sync);
        send_byte(sb.first_sync);
        send_byte(sb.second_sync);
        // good frame with the signed extremes, deltas taken from zero
        send_frame({32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b0, FRAME_LEN);
        // back to back, bad crc: stored counts held, zero deltas
        send_frame({32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000}, 1'b1, FRAME_LEN);
        last_counts = {32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_idle();
                write_reg(CFG_FIRST_SYNC, sync_a[p]);
                write_reg(CFG_SECOND_SYNC, sync_b[p]);
            end
            // idling pattern: none, sender, receiver, both
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                for (int w = 0; w < NUM_WHEELS; w++) cnt[w] = pick_count(last_counts[w]);
                pick = $urandom_range(99);
                if (pick < 62) begin
                    send_frame(cnt, 1'b0, FRAME_LEN);
                    last_counts = cnt;
                end else if (pick < 72) begin
                    send_frame(cnt, 1'b1, FRAME_LEN);
                end else if (pick < 80) begin
                    // cut short: the next bytes get swallowed into its body
                    send_frame(cnt, 1'b0, $urandom_range(FRAME_LEN - 1, 3));
                end else if (pick < 88) begin
                    // wrong second header byte, sometimes the first sync value
                    if (sb.first_sync != sb.second_sync && $urandom_range(1))
                        bad_second = sb.first_sync;
                    else
                        bad_second = sb.second_sync ^ BYTE_W'($urandom_range(255, 1));
                    send_byte(sb.first_sync);
                    send_byte(bad_second);
                end else if (pick < 96) begin
                    repeat ($urandom_range(6, 1)) begin
                        case ($urandom_range(3))
                            0: send_byte(sb.first_sync);
                            1: send_byte(sb.second_sync);
                            default: send_byte(BYTE_W'($urandom_range(255)));
                        endcase
                    end
                end else begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("crc16_framed_counter_receiver verification clean");
        end else begin
            $display("crc16_framed_counter_receiver verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cfc_pkg.sv
hdl/cfc_deframer.sv
hdl/crc16_framed_counter_receiver.sv
tb/wheel_frame_check_pkg.sv
tb/testbench.sv
